// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers used by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, masked while in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// next-cycle implication, masked while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/opf_pkg.sv
// ----------------------------------------------------------------------------
// opf_pkg
// types and constants of the object pool handle allocator
// ----------------------------------------------------------------------------
package opf_pkg;

  localparam int HANDLE_W      = 8;
  localparam int HANDLE_SLOTS  = 256;
  localparam int POOL_SIZE_DEF = 256;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_TRY   = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_INVALID   = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_POP,
    S_CHECK
  } state_t;

  typedef struct packed {
    logic [1:0]          command;
    logic [HANDLE_W-1:0] handle_in;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    status_t             status;
  } rsp_t;

endpackage

// File: src/opf_ram.sv
// ----------------------------------------------------------------------------
// opf_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module opf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/object_pool_fifo_reuse.sv
// ----------------------------------------------------------------------------
// object_pool_fifo_reuse
// handle allocator with a fifo free list and an allocated bitmap
// ----------------------------------------------------------------------------
// After reset the bitmap is cleared one entry a cycle, min(POOL_SIZE, 256)
// entries, with req_ready low. A request is then taken whenever the block is
// idle and the response register is empty or being drained. A fresh grant,
// an exhausted pool, an empty try, a release out of range or into a full
// list, or an unknown command answers in the cycle after acceptance, and the
// next request can follow at once if that response is taken. A grant from
// the free list or a release first reads the free-list or bitmap ram, so
// it answers from S_POP or S_CHECK and blocks new requests until then.
module object_pool_fifo_reuse #(
  parameter int POOL_SIZE = opf_pkg::POOL_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  opf_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output opf_pkg::rsp_t rsp
);
  import opf_pkg::*;

`include "assert_macros.svh"

  localparam int USABLE = (POOL_SIZE < HANDLE_SLOTS) ? POOL_SIZE : HANDLE_SLOTS;
  localparam int AW     = $clog2(USABLE);
  localparam int FW     = $clog2(HANDLE_SLOTS);
  localparam int CW     = FW + 1;

  state_t              state, state_next;
  logic [AW-1:0]       clr_addr, clr_addr_next;
  logic [FW-1:0]       head, head_next, tail, tail_next;
  logic [CW-1:0]       free_count, free_count_next;
  logic [CW-1:0]       fresh, fresh_next;
  logic [HANDLE_W-1:0] hq, hq_next;
  logic                rsp_load;
  rsp_t                rsp_next;

  logic                bm_we;
  logic [AW-1:0]       bm_waddr;
  logic [0:0]          bm_wdata, bm_rdata;
  logic                ff_we;
  logic [HANDLE_W-1:0] ff_rdata;

  logic acc, in_range;

  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign acc       = req_valid && req_ready;
  assign in_range  = {1'b0, req.handle_in} < CW'(USABLE);

  opf_ram #(.WIDTH(1), .DEPTH(USABLE)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (req.handle_in[AW-1:0]),
    .rdata (bm_rdata)
  );

  opf_ram #(.WIDTH(HANDLE_W), .DEPTH(HANDLE_SLOTS)) u_free_fifo (
    .clk   (clk),
    .we    (ff_we),
    .waddr (tail),
    .wdata (hq),
    .raddr (head),
    .rdata (ff_rdata)
  );

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    head_next       = head;
    tail_next       = tail;
    free_count_next = free_count;
    fresh_next      = fresh;
    hq_next         = hq;
    rsp_load        = 1'b0;
    rsp_next        = '{handle_out: '0, status: ST_OK};
    bm_we           = 1'b0;
    bm_waddr        = clr_addr;
    bm_wdata        = 1'b0;
    ff_we           = 1'b0;
    case (state)
      S_CLEAR: begin
        bm_we         = 1'b1;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(USABLE - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          case (req.command)
            CMD_ALLOC, CMD_TRY: begin
              if (free_count != '0) begin
                head_next       = head + FW'(1);
                free_count_next = free_count - CW'(1);
                state_next      = S_POP;
              end else if (req.command == CMD_TRY) begin
                rsp_load        = 1'b1;
                rsp_next.status = ST_EMPTY;
              end else if (fresh < CW'(USABLE)) begin
                bm_we               = 1'b1;
                bm_waddr            = fresh[AW-1:0];
                bm_wdata            = 1'b1;
                fresh_next          = fresh + CW'(1);
                rsp_load            = 1'b1;
                rsp_next.handle_out = fresh[HANDLE_W-1:0];
              end else begin
                rsp_load        = 1'b1;
                rsp_next.status = ST_EXHAUSTED;
              end
            end
            CMD_FREE: begin
              if (in_range && !free_count[CW-1]) begin
                hq_next    = req.handle_in;
                state_next = S_CHECK;
              end else begin
                rsp_load        = 1'b1;
                rsp_next.status = ST_INVALID;
              end
            end
            default: begin
              rsp_load        = 1'b1;
              rsp_next.status = ST_INVALID;
            end
          endcase
        end
      end
      S_POP: begin
        bm_we               = 1'b1;
        bm_waddr            = ff_rdata[AW-1:0];
        bm_wdata            = 1'b1;
        rsp_load            = 1'b1;
        rsp_next.handle_out = ff_rdata;
        state_next          = S_IDLE;
      end
      S_CHECK: begin
        rsp_load   = 1'b1;
        state_next = S_IDLE;
        if (bm_rdata[0]) begin
          bm_we           = 1'b1;
          bm_waddr        = hq[AW-1:0];
          ff_we           = 1'b1;
          tail_next       = tail + FW'(1);
          free_count_next = free_count + CW'(1);
        end else begin
          rsp_next.status = ST_INVALID;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      head       <= '0;
      tail       <= '0;
      free_count <= '0;
      fresh      <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      head       <= head_next;
      tail       <= tail_next;
      free_count <= free_count_next;
      fresh      <= fresh_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hq <= hq_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // ram read stages always end in a response beat
  `ASSERT_NEXT(a_pop_rsp, state == S_POP, rsp_valid && state == S_IDLE, "pop gave no beat")
  `ASSERT_NEXT(a_chk_rsp, state == S_CHECK, rsp_valid && state == S_IDLE, "release gave no beat")
  // list occupancy stays within the list depth and fresh handles within the pool
  `ASSERT_CLK(a_count, free_count <= CW'(HANDLE_SLOTS) && fresh <= CW'(USABLE), "count overflow")
  // an accepted request is followed by a response beat or a ram read stage
  `ASSERT_NEXT(a_accept, acc, rsp_valid || state == S_POP || state == S_CHECK, "request lost")

endmodule
